>>> rtl/e2c_pkg.sv
`default_nettype none

package e2c_pkg;

  // Operand width of the shared subtractor: remainder (17 bits) plus one shifted-in bit
  localparam int unsigned SubW = 18;

  localparam int unsigned TsW   = 32;
  localparam int unsigned RemW  = 17;
  localparam int unsigned DaysW = 16;
  localparam int unsigned CntW  = 5;

  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  localparam int unsigned OutW  = YearW + MonthW + DayW + HourW + MinuteW + SecondW;
  localparam int unsigned OutBW = ((OutW + 7) / 8) * 8;

  // Divisors for the three long-division passes
  localparam logic [RemW-1:0] DivDay  = 17'd86400;
  localparam logic [RemW-1:0] DivHour = 17'd3600;
  localparam logic [RemW-1:0] DivMin  = 17'd60;

  // Step counts minus one: bits of dividend fed through each pass
  localparam logic [CntW-1:0] CntDay  = 5'd31;
  localparam logic [CntW-1:0] CntHour = 5'd16;
  localparam logic [CntW-1:0] CntMin  = 5'd11;

  localparam logic [YearW-1:0] EpochYear = 12'd1970;
  localparam logic [6:0]       Y100Init  = 7'd70;
  localparam logic [6:0]       Y100Last  = 7'd99;
  localparam logic [8:0]       Y400Init  = 9'd370;
  localparam logic [8:0]       Y400Last  = 9'd399;

  localparam logic [MonthW-1:0] MonJan  = 4'd0;
  localparam logic [MonthW-1:0] MonFeb  = 4'd1;
  localparam logic [MonthW-1:0] MonLast = 4'd11;

  // Result of the shared subtract/compare unit
  typedef struct packed {
    logic [SubW-1:0] diff;
    logic            borrow;
  } sub_res_t;

  // Length of month mo (0 = January), February follows the leap flag
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mo, input logic leap);
    logic [DayW-1:0] len;
    begin
      unique case (mo)
        MonFeb:                    len = leap ? 5'd29 : 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/e2c_sub.sv
`default_nettype none

module e2c_sub
  import e2c_pkg::*;
(
  input  logic [SubW-1:0] a_i,
  input  logic [SubW-1:0] b_i,
  output sub_res_t        res_o
);

  logic [SubW:0] full;

  // One wide subtract; the borrow doubles as the a < b compare
  assign full         = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff   = full[SubW-1:0];
  assign res_o.borrow = full[SubW];

endmodule

`default_nettype wire

>>> rtl/epoch_seconds_to_calendar_top.sv
`default_nettype none

// Seconds-since-epoch to calendar converter.
//
// Input channel s_axis_*: one item is a 32-bit unsigned count of seconds since
// 1970-01-01 00:00:00. Output channel m_axis_*: one item per input, holding
// year, month, day, hour, minute and second.
//
// All arithmetic runs through a single 18-bit subtract/compare unit under a
// small sequencer. Three restoring long divisions split the count into days
// (32 steps), hours (17 steps) and minutes/seconds (12 steps); whole years
// are then stripped from the day count one per cycle (up to 137 steps), and
// whole months one per cycle (up to 12 steps). s_axis_tready_o is high only
// while the sequencer is idle, so one item is in work at a time and the next
// item is accepted no earlier than the cycle after the result loads.
//
// The result sits in an output register. A stalled receiver does not stop the
// next item from being accepted and worked on; only its final load waits
// until the output register has been taken. Reset clears the sequencer and
// the output valid; no other state is kept.

module epoch_seconds_to_calendar_top
  import e2c_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [TsW-1:0]   s_axis_tdata_i,   // [31:0] timestamp

  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OutBW-1:0] m_axis_tdata_o    // [11:0] year, [15:12] month, [20:16] day,
                                             // [25:21] hour, [31:26] minute,
                                             // [37:32] second, [39:38] zero
);

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StYear  = 3'd2;
  localparam logic [2:0] StMonth = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  // Division passes
  localparam logic [1:0] PhDay  = 2'd0;
  localparam logic [1:0] PhHour = 2'd1;
  localparam logic [1:0] PhMin  = 2'd2;

  logic [2:0]         state_q, state_d;
  logic [1:0]         ph_q, ph_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [TsW-1:0]     quo_q, quo_d;     // dividend shifts out the top, quotient in the bottom
  logic [RemW-1:0]    rem_q, rem_d;
  logic [DaysW-1:0]   days_q, days_d;   // day count, then day within the year / month
  logic [HourW-1:0]   hour_q, hour_d;
  logic [MinuteW-1:0] min_q, min_d;
  logic [SecondW-1:0] sec_q, sec_d;
  logic [YearW-1:0]   year_q, year_d;
  logic [6:0]         y100_q, y100_d;   // year mod 100
  logic [8:0]         y400_q, y400_d;   // year mod 400
  logic [MonthW-1:0]  mo_q, mo_d;

  logic               out_valid_q, out_valid_d;
  logic [OutBW-1:0]   out_data_q, out_data_d;

  logic [SubW-1:0]    sub_a, sub_b;
  sub_res_t           sub_res;
  logic [RemW-1:0]    divisor;
  logic               leap;
  logic [DayW-1:0]    mlen;
  logic [TsW-1:0]     div_quo;
  logic [RemW-1:0]    div_rem;
  logic               out_take;
  logic               load_out;

  assign leap = (year_q[1:0] == 2'b00) && ((y100_q != 7'd0) || (y400_q == 9'd0));
  assign mlen = month_len(mo_q, leap);

  always_comb begin
    unique case (ph_q)
      PhHour:  divisor = DivHour;
      PhMin:   divisor = DivMin;
      default: divisor = DivDay;
    endcase
  end

  // Operand select for the shared unit
  always_comb begin
    unique case (state_q)
      StDiv: begin
        sub_a = {rem_q, quo_q[TsW-1]};
        sub_b = {1'b0, divisor};
      end
      StYear: begin
        sub_a = {2'b00, days_q};
        sub_b = {9'd0, 8'd0, leap} + 18'd365;
      end
      StMonth: begin
        sub_a = {2'b00, days_q};
        sub_b = {{(SubW-DayW){1'b0}}, mlen};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  e2c_sub u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  // One restoring division step: keep the difference when it did not borrow
  always_comb begin
    if (sub_res.borrow) begin
      div_rem = sub_a[RemW-1:0];
      div_quo = {quo_q[TsW-2:0], 1'b0};
    end else begin
      div_rem = sub_res.diff[RemW-1:0];
      div_quo = {quo_q[TsW-2:0], 1'b1};
    end
  end

  assign out_take = out_valid_q && m_axis_tready_i;
  assign load_out = (state_q == StDone) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    days_d   = days_q;
    hour_d   = hour_q;
    min_d    = min_q;
    sec_d    = sec_q;
    year_d   = year_q;
    y100_d   = y100_q;
    y400_d   = y400_q;
    mo_d     = mo_q;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          quo_d   = s_axis_tdata_i;
          rem_d   = '0;
          cnt_d   = CntDay;
          ph_d    = PhDay;
          state_d = StDiv;
        end
      end
      StDiv: begin
        quo_d = div_quo;
        rem_d = div_rem;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          unique case (ph_q)
            PhDay: begin
              // days out, seconds of the day go on to the hour pass
              days_d = div_quo[DaysW-1:0];
              quo_d  = {div_rem, {(TsW-RemW){1'b0}}};
              rem_d  = '0;
              cnt_d  = CntHour;
              ph_d   = PhHour;
            end
            PhHour: begin
              hour_d = div_quo[HourW-1:0];
              quo_d  = {div_rem[11:0], 20'd0};
              rem_d  = '0;
              cnt_d  = CntMin;
              ph_d   = PhMin;
            end
            default: begin
              min_d   = div_quo[MinuteW-1:0];
              sec_d   = div_rem[SecondW-1:0];
              year_d  = EpochYear;
              y100_d  = Y100Init;
              y400_d  = Y400Init;
              state_d = StYear;
            end
          endcase
        end
      end
      StYear: begin
        if (sub_res.borrow) begin
          mo_d    = MonJan;
          state_d = StMonth;
        end else begin
          // strip one whole year
          days_d = sub_res.diff[DaysW-1:0];
          year_d = year_q + 12'd1;
          y100_d = (y100_q == Y100Last) ? 7'd0 : y100_q + 7'd1;
          y400_d = (y400_q == Y400Last) ? 9'd0 : y400_q + 9'd1;
        end
      end
      StMonth: begin
        if (sub_res.borrow || (mo_q == MonLast)) begin
          state_d = StDone;
        end else begin
          days_d = sub_res.diff[DaysW-1:0];
          mo_d   = mo_q + 4'd1;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: a fresh load wins over the take in the same cycle
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {{(OutBW-OutW){1'b0}},
                     sec_q,
                     min_q,
                     hour_q,
                     days_q[DayW-1:0] + 5'd1,
                     mo_q + 4'd1,
                     year_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ph_q        <= PhDay;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_d_hold: begin
      quo_q      <= quo_d;
      rem_q      <= rem_d;
      days_q     <= days_d;
      hour_q     <= hour_d;
      min_q      <= min_d;
      sec_q      <= sec_d;
      year_q     <= year_d;
      y100_q     <= y100_d;
      y400_q     <= y400_d;
      mo_q       <= mo_d;
      out_data_q <= out_data_d;
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // An accepted item always starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == StDiv))
    else $error("accepted item did not start the division pass");

  // Month scan never walks past December
  a_month_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMonth) |-> (mo_q <= MonLast))
    else $error("month index out of range");

  // A loaded result carries a real month, day and hour
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[15:12] != 4'd0) && (m_axis_tdata_o[15:12] <= 4'd12)
                         && (m_axis_tdata_o[20:16] != 5'd0)
                         && (m_axis_tdata_o[25:21] <= 5'd23)))
    else $error("result field out of range");

  // The year pass only starts after the minute pass of the divider
  a_year_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == StYear) |-> ($past(ph_q) == PhMin))
    else $error("year pass entered before the divider finished");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;
  import e2c_pkg::*;

  // Stop the run here if the converter hangs.
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned RandomItems = 1700;
  // Wait after the drain, longer than the worst converter latency, for stray results.
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } calendar_t;

  // One directed item; known_date marks rows whose date is typed in below.
  typedef struct packed {
    logic [TsW-1:0] ts;
    logic           known_date;
    calendar_t      date;
  } stim_row_t;

  localparam int NumDirected = 23;
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{32'd59,         1'b0, '0},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
    '{32'd86400,      1'b0, '0},
    '{32'd31535999,   1'b0, '0},
    '{32'd31536000,   1'b1, '{12'd1971, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{32'd68169600,   1'b0, '0},  // first leap day
    '{32'd68255999,   1'b0, '0},
    '{32'd68256000,   1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'd946684800,  1'b0, '0},
    '{32'd951782400,  1'b0, '0},  // leap day of a 400-year century
    '{32'd978220800,  1'b0, '0},  // last day of a 366-day year
    '{32'd4107542399, 1'b0, '0},  // 2100 is not a leap year
    '{32'd4107542400, 1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},
    '{32'h8000_0000,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}}
  };

  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [TsW-1:0]   s_axis_tdata;    // [31:0] timestamp
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OutBW-1:0] m_axis_tdata;    // [11:0] year, [15:12] month, [20:16] day,
                                     // [25:21] hour, [31:26] minute, [37:32] second

  calendar_t   expected_dates [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          steady;               // high: neither side idles

  epoch_seconds_to_calendar_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Count cycles and give up at the limit.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned year_days(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(input int unsigned mo, input bit leap);
    return MonthDays[mo] + ((mo == 1 && leap) ? 1 : 0);
  endfunction

  // Split seconds into time of day and whole days, then strip whole years and months.
  function automatic calendar_t calendar_from_seconds(input logic [TsW-1:0] ts);
    calendar_t   c;
    int unsigned rest;
    int unsigned days;
    int unsigned y;
    int unsigned mo;
    bit          leap;
    rest     = ts;
    c.second = SecondW'(rest % 60);
    rest     = rest / 60;
    c.minute = MinuteW'(rest % 60);
    rest     = rest / 60;
    c.hour   = HourW'(rest % 24);
    days     = rest / 24;
    y        = 1970;
    while (days >= year_days(y)) begin
      days = days - year_days(y);
      y++;
    end
    leap = leap_year(y);
    mo   = 0;
    while (mo < 11 && days >= month_days(mo, leap)) begin
      days = days - month_days(mo, leap);
      mo++;
    end
    c.year  = YearW'(y);
    c.month = MonthW'(mo + 1);
    c.day   = DayW'(days + 1);
    return c;
  endfunction

  // Days from the epoch to 1 January of year y.
  function automatic longint days_to_year(input int unsigned y);
    longint      n;
    int unsigned k;
    n = 0;
    for (k = 1970; k < y; k++) n += year_days(k);
    return n;
  endfunction

  // Pick a timestamp: uniform in four of ten draws, the rest close to year, month
  // and day edges or near either end of the range.
  function automatic logic [TsW-1:0] random_timestamp();
    int unsigned kind;
    int unsigned y;
    int unsigned mo;
    int unsigned k;
    longint      days;
    longint      t;
    kind = $urandom_range(0, 9);
    case (kind)
      4, 5: begin
        y = $urandom_range(1971, 2106);
        t = days_to_year(y) * 86400 + $urandom_range(0, 6) - 3;
      end
      6, 7: begin
        y    = $urandom_range(1970, 2105);
        mo   = $urandom_range(0, 11);
        days = days_to_year(y) + $urandom_range(0, 1);
        for (k = 0; k < mo; k++) days += month_days(k, leap_year(y));
        t = days * 86400 + $urandom_range(0, 6) - 3;
      end
      8:       t = $urandom_range(0, 200000);
      9:       t = 64'hFFFF_FFFF - $urandom_range(0, 200000);
      default: t = $urandom();
    endcase
    return t[TsW-1:0];
  endfunction

  // Hold off for a random gap, then present one item and hold it until accepted.
  task automatic send_timestamp(input logic [TsW-1:0] ts, input logic known_date,
                                input calendar_t date);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_dates.push_back(known_date ? date : calendar_from_seconds(ts));
  endtask

  // Stimulus: reset, the directed rows, then random items in phases.
  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    steady        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < NumDirected; n++) begin
      send_timestamp(DirectedRows[n].ts, DirectedRows[n].known_date, DirectedRows[n].date);
    end

    for (n = 0; n < RandomItems; n++) begin
      // Every 100 items, choose a phase with or without idling.
      if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      send_timestamp(random_timestamp(), 1'b0, '0);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    steady        = 1'b0;

    // Drain all expected dates, then watch for stray results.
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receive side: stall at random, take each result and compare it with the oldest date.
  initial begin
    int unsigned stall;
    calendar_t   got;
    calendar_t   want;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);

      got.year   = m_axis_tdata[11:0];
      got.month  = m_axis_tdata[15:12];
      got.day    = m_axis_tdata[20:16];
      got.hour   = m_axis_tdata[25:21];
      got.minute = m_axis_tdata[31:26];
      got.second = m_axis_tdata[37:32];

      if (expected_dates.size() == 0) begin
        $error("result with no date pending: %0d-%0d-%0d %0d:%0d:%0d",
               got.year, got.month, got.day, got.hour, got.minute, got.second);
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        if (got.year != want.year) begin
          $error("year: expected %0d, got %0d", want.year, got.year);
          mismatches++;
        end
        if (got.month != want.month) begin
          $error("month: expected %0d, got %0d", want.month, got.month);
          mismatches++;
        end
        if (got.day != want.day) begin
          $error("day: expected %0d, got %0d", want.day, got.day);
          mismatches++;
        end
        if (got.hour != want.hour) begin
          $error("hour: expected %0d, got %0d", want.hour, got.hour);
          mismatches++;
        end
        if (got.minute != want.minute) begin
          $error("minute: expected %0d, got %0d", want.minute, got.minute);
          mismatches++;
        end
        if (got.second != want.second) begin
          $error("second: expected %0d, got %0d", want.second, got.second);
          mismatches++;
        end
      end
    end
  end

endmodule
